/* src/tpg_pkg.sv */
// Package for the triplanar texture coordinate generator.
// Holds widths, projection mode codes, config register indexes and the stage struct.
// No dependencies.
`default_nettype none
package tpg_pkg;
	localparam int COORD_W = 32;
	localparam int UNIT_W = 16;
	localparam int UNIT_FRAC = 14;
	localparam int COORD_FRAC = 16;
	localparam int OFFSET_FRAC = 13;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [3:0] {
		MODE_WAUTO = 4'd0,
		MODE_WZY   = 4'd1,
		MODE_WXZ   = 4'd2,
		MODE_WXY   = 4'd3,
		MODE_LAUTO = 4'd4,
		MODE_LZY   = 4'd5,
		MODE_LXZ   = 4'd6,
		MODE_LXY   = 4'd7,
		MODE_UNWRAP = 4'd8
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_QW = 2'd0,
		REG_QX = 2'd1,
		REG_QY = 2'd2,
		REG_QZ = 2'd3
	} cfg_reg_t;

	// item controls carried along the pipeline
	typedef struct packed {
		logic [3:0]  mode;
		logic [1:0]  turns;
		logic [15:0] scale;
		logic [31:0] offset;
		logic [31:0] vu;
		logic [31:0] vv;
	} ctl_t;

	// pick the (u,v) pair of a plane selection: 0 zy, 1 xz, 2 xy
	typedef logic [1:0] plane_t;
	localparam plane_t PL_ZY = 2'd0;
	localparam plane_t PL_XZ = 2'd1;
	localparam plane_t PL_XY = 2'd2;

	function automatic plane_t auto_plane(input logic signed [33:0] nx,
		input logic signed [33:0] ny, input logic signed [33:0] nz);
		logic [33:0] ax, ay, az;
		ax = nx[33] ? -nx : nx;
		ay = ny[33] ? -ny : ny;
		az = nz[33] ? -nz : nz;
		if (ax < ay && az < ay) return PL_XZ;
		else if (ax < az) return PL_XY;
		else return PL_ZY;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v,
		output logic clip);
		clip = 1'b0;
		if (v > 66'sd2147483647) begin
			clip = 1'b1;
			return 32'sh7fffffff;
		end
		if (v < -66'sd2147483648) begin
			clip = 1'b1;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction
endpackage
`default_nettype wire

/* src/tpg_stream_if.sv */
// Valid/ready channel interfaces: config writes, vertices and texture coordinates.
// Depends on nothing.
`default_nettype none
interface tpg_cfg_if ();
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [15:0] wdata;
	modport source(output valid, output index, output wdata, input ready);
	modport sink(input valid, input index, input wdata, output ready);
endinterface

interface tpg_vert_if ();
	logic valid;
	logic ready;
	logic [31:0] pos_x, pos_y, pos_z;
	logic [15:0] norm_x, norm_y, norm_z;
	logic [31:0] vert_u, vert_v;
	logic [3:0] proj_mode;
	logic [1:0] quarter_turns;
	logic [15:0] scale_pair;
	logic [31:0] offset_pair;
	modport source(output valid, output pos_x, output pos_y, output pos_z,
		output norm_x, output norm_y, output norm_z, output vert_u, output vert_v,
		output proj_mode, output quarter_turns, output scale_pair,
		output offset_pair, input ready);
	modport sink(input valid, input pos_x, input pos_y, input pos_z,
		input norm_x, input norm_y, input norm_z, input vert_u, input vert_v,
		input proj_mode, input quarter_turns, input scale_pair,
		input offset_pair, output ready);
endinterface

interface tpg_tex_if ();
	logic valid;
	logic ready;
	logic [31:0] tex_u, tex_v;
	logic saturated;
	modport source(output valid, output tex_u, output tex_v, output saturated,
		input ready);
	modport sink(input valid, input tex_u, input tex_v, input saturated,
		output ready);
endinterface
`default_nettype wire

/* src/triplanar_texcoord_generator.sv */
// Triplanar texture coordinate generator, top level.
// A result passes through six register stages after its input transfer.
// Throughput: one vertex per cycle while the output is not stalled; input is held off
// after reset and after each config write, until the rebuilt rotation matrix is in place.
// Reset (arst_n, async) clears valid bits and loads the identity quaternion.
// Uses tpg_pkg, tpg_*_if, tpg_matrix, tpg_post.
`default_nettype none
module triplanar_texcoord_generator (
	input  wire logic clk,
	input  wire logic arst_n,
	tpg_cfg_if.sink  cfg,
	tpg_vert_if.sink vert,
	tpg_tex_if.source tex
);
	logic signed [15:0] qw_q, qx_q, qy_q, qz_q;
	logic signed [19:0] m [9];
	logic en;
	logic mat_busy_q;
	assign en = !tex.valid || tex.ready;
	assign vert.ready = en && !mat_busy_q;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qw_q <= 16'sd16384; qx_q <= '0; qy_q <= '0; qz_q <= '0;
		end else if (cfg.valid) begin
			case (tpg_pkg::cfg_reg_t'(cfg.index))
				tpg_pkg::REG_QW: qw_q <= cfg.wdata;
				tpg_pkg::REG_QX: qx_q <= cfg.wdata;
				tpg_pkg::REG_QY: qy_q <= cfg.wdata;
				tpg_pkg::REG_QZ: qz_q <= cfg.wdata;
				default: qw_q <= qw_q;
			endcase
		end
	end

	// matrix products register the new quaternion in the cycle after a write; block input meanwhile
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mat_busy_q <= 1'b1;
		else mat_busy_q <= cfg.valid && cfg.ready;
	end

	tpg_matrix u_mat (.clk, .qw(qw_q), .qx(qx_q), .qy(qy_q), .qz(qz_q), .m_q(m));

	// Pipeline: capture, rotate products, rotate sums, select, scale/turn, offset.
	// stage 1: capture
	logic valid_s1;
	logic signed [31:0] p_s1 [3];
	logic signed [15:0] n_s1 [3];
	tpg_pkg::ctl_t ctl_s1;
	// stage 2: products of matrix and vectors
	logic valid_s2;
	logic signed [51:0] pp_s2 [9];
	logic signed [35:0] np_s2 [9];
	logic signed [31:0] p_s2 [3];
	logic signed [15:0] n_s2 [3];
	tpg_pkg::ctl_t ctl_s2;
	// stage 3: rotated vectors
	logic valid_s3;
	logic signed [31:0] lp_s3 [3];
	logic signed [33:0] ln_s3 [3];
	logic lclip_s3;
	logic signed [31:0] p_s3 [3];
	logic signed [15:0] n_s3 [3];
	tpg_pkg::ctl_t ctl_s3;
	// stage 4: selected pair
	logic valid_s4;
	logic signed [31:0] u_s4, v_s4;
	logic clip_s4;
	tpg_pkg::ctl_t ctl_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0; valid_s2 <= 1'b0; valid_s3 <= 1'b0; valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= vert.valid && vert.ready; valid_s2 <= valid_s1;
			valid_s3 <= valid_s2; valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0] <= vert.pos_x; p_s1[1] <= vert.pos_y; p_s1[2] <= vert.pos_z;
			n_s1[0] <= vert.norm_x; n_s1[1] <= vert.norm_y; n_s1[2] <= vert.norm_z;
			ctl_s1 <= '{mode: vert.proj_mode, turns: vert.quarter_turns,
				scale: vert.scale_pair, offset: vert.offset_pair,
				vu: vert.vert_u, vv: vert.vert_v};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++) begin
					pp_s2[3*r+c] <= 52'(m[3*r+c]) * 52'(p_s1[c]);
					np_s2[3*r+c] <= 36'(m[3*r+c]) * 36'(n_s1[c]);
				end
			p_s2 <= p_s1; n_s2 <= n_s1; ctl_s2 <= ctl_s1;
		end
	end

	logic signed [65:0] psum [3];
	logic signed [39:0] nsum [3];
	logic signed [31:0] lp [3];
	logic lc [3];
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			psum[r] = (66'(pp_s2[3*r]) + 66'(pp_s2[3*r+1]) + 66'(pp_s2[3*r+2])
				+ 66'sd8192) >>> tpg_pkg::UNIT_FRAC;
			nsum[r] = (40'(np_s2[3*r]) + 40'(np_s2[3*r+1]) + 40'(np_s2[3*r+2])
				+ 40'sd8192) >>> tpg_pkg::UNIT_FRAC;
			lp[r] = tpg_pkg::sat32(psum[r], lc[r]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lp_s3 <= lp;
			for (int r = 0; r < 3; r++) ln_s3[r] <= 34'(nsum[r]);
			lclip_s3 <= lc[0] | lc[1] | lc[2];
			p_s3 <= p_s2; n_s3 <= n_s2; ctl_s3 <= ctl_s2;
		end
	end

	tpg_pkg::plane_t pl;
	logic signed [31:0] su, sv;
	logic sclip;
	always_comb begin
		sclip = 1'b0;
		case (tpg_pkg::mode_t'(ctl_s3.mode))
			tpg_pkg::MODE_WAUTO: pl = tpg_pkg::auto_plane(34'(n_s3[0]), 34'(n_s3[1]),
				34'(n_s3[2]));
			tpg_pkg::MODE_WZY, tpg_pkg::MODE_LZY: pl = tpg_pkg::PL_ZY;
			tpg_pkg::MODE_WXZ, tpg_pkg::MODE_LXZ: pl = tpg_pkg::PL_XZ;
			tpg_pkg::MODE_LAUTO: pl = tpg_pkg::auto_plane(ln_s3[0], ln_s3[1], ln_s3[2]);
			default: pl = tpg_pkg::PL_XY;
		endcase
		if (ctl_s3.mode >= 4'd4 && ctl_s3.mode <= 4'd7) begin
			sclip = lclip_s3;
			case (pl)
				tpg_pkg::PL_ZY: begin su = lp_s3[2]; sv = lp_s3[1]; end
				tpg_pkg::PL_XZ: begin su = lp_s3[0]; sv = lp_s3[2]; end
				default: begin su = lp_s3[0]; sv = lp_s3[1]; end
			endcase
		end else if (ctl_s3.mode <= 4'd3) begin
			case (pl)
				tpg_pkg::PL_ZY: begin su = p_s3[2]; sv = p_s3[1]; end
				tpg_pkg::PL_XZ: begin su = p_s3[0]; sv = p_s3[2]; end
				default: begin su = p_s3[0]; sv = p_s3[1]; end
			endcase
		end else begin
			su = ctl_s3.vu; sv = ctl_s3.vv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s4 <= su; v_s4 <= sv; clip_s4 <= sclip; ctl_s4 <= ctl_s3;
		end
	end

	tpg_post u_post (
		.clk, .arst_n, .en,
		.in_valid(valid_s4), .in_u(u_s4), .in_v(v_s4), .in_clip(clip_s4),
		.in_turns(ctl_s4.turns), .in_scale(ctl_s4.scale), .in_offset(ctl_s4.offset),
		.out_valid(tex.valid), .out_u(tex.tex_u), .out_v(tex.tex_v),
		.out_clip(tex.saturated)
	);

`ifndef SYNTH
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tex.valid && !tex.ready |=> tex.valid && $stable(tex.tex_u))
		else $error("result changed under stall");
	a_no_accept_stall: assert property (@(posedge clk) disable iff (!arst_n)
		tex.valid && !tex.ready |-> !vert.ready)
		else $error("input taken while pipeline stalled");
	a_pipe_advance: assert property (@(posedge clk) disable iff (!arst_n)
		vert.valid && vert.ready |=> valid_s1)
		else $error("accepted vertex lost at stage 1");
`endif
endmodule
`default_nettype wire

/* src/tpg_matrix.sv */
// Rotation matrix builder: quaternion registers to a 3x3 Q6.14 matrix.
// Registered products then registered rounded sums. Depends on tpg_pkg.
`default_nettype none
module tpg_matrix (
	input  wire logic clk,
	input  wire logic signed [15:0] qw, qx, qy, qz,
	output logic signed [19:0] m_q [9]
);
	logic signed [31:0] ww_q, xx_q, yy_q, zz_q, xy_q, wz_q, xz_q, wy_q, yz_q, wx_q;
	logic signed [35:0] raw [9];

	always_ff @(posedge clk) begin
		ww_q <= qw * qw; xx_q <= qx * qx; yy_q <= qy * qy; zz_q <= qz * qz;
		xy_q <= qx * qy; wz_q <= qw * qz; xz_q <= qx * qz; wy_q <= qw * qy;
		yz_q <= qy * qz; wx_q <= qw * qx;
	end

	always_comb begin
		raw[0] = 36'(ww_q) + 36'(xx_q) - 36'(yy_q) - 36'(zz_q);
		raw[1] = (36'(xy_q) - 36'(wz_q)) <<< 1;
		raw[2] = (36'(xz_q) + 36'(wy_q)) <<< 1;
		raw[3] = (36'(xy_q) + 36'(wz_q)) <<< 1;
		raw[4] = 36'(ww_q) - 36'(xx_q) + 36'(yy_q) - 36'(zz_q);
		raw[5] = (36'(yz_q) - 36'(wx_q)) <<< 1;
		raw[6] = (36'(xz_q) - 36'(wy_q)) <<< 1;
		raw[7] = (36'(yz_q) + 36'(wx_q)) <<< 1;
		raw[8] = 36'(ww_q) - 36'(xx_q) - 36'(yy_q) + 36'(zz_q);
	end

	// round half up to 14 fraction bits; a non-unit quaternion can reach +-2^18
	always_ff @(posedge clk) begin
		for (int i = 0; i < 9; i++)
			m_q[i] <= 20'((raw[i] + 36'sd8192) >>> tpg_pkg::UNIT_FRAC);
	end
endmodule
`default_nettype wire

/* src/tpg_post.sv */
// Scale, quarter turn and offset of a selected uv pair, two register stages.
// Depends on tpg_pkg.
`default_nettype none
module tpg_post (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic in_valid,
	input  wire logic signed [31:0] in_u, in_v,
	input  wire logic in_clip,
	input  wire logic [1:0] in_turns,
	input  wire logic [15:0] in_scale,
	input  wire logic [31:0] in_offset,
	output logic out_valid,
	output logic signed [31:0] out_u, out_v,
	output logic out_clip
);
	function automatic logic signed [31:0] scale_one(input logic signed [31:0] v,
		input logic signed [7:0] e, output logic clip);
		logic [6:0] s;
		logic signed [65:0] w;
		clip = 1'b0;
		if (e < 0) begin
			s = (-9'(e) > 9'd63) ? 7'd63 : 7'(-9'(e));
			return 32'(v >>> s);
		end
		if (v == 0) return 32'sd0;
		if (e >= 8'sd32) begin
			clip = 1'b1;
			return v[31] ? 32'sh80000000 : 32'sh7fffffff;
		end
		w = 66'(v) <<< e[4:0];
		return tpg_pkg::sat32(w, clip);
	endfunction

	function automatic logic signed [31:0] neg(input logic signed [31:0] v,
		output logic clip);
		clip = (v == 32'sh80000000);
		return clip ? 32'sh7fffffff : -v;
	endfunction

	logic signed [31:0] su, sv, tu, tv;
	logic c0, c1, c2, c3;
	logic valid_s1;
	logic signed [31:0] u_s1, v_s1;
	logic clip_s1;
	logic [31:0] off_s1;

	always_comb begin
		su = scale_one(in_u, in_scale[7:0], c0);
		sv = scale_one(in_v, in_scale[15:8], c1);
		c2 = 1'b0; c3 = 1'b0;
		case (in_turns)
			2'd1: begin tu = neg(sv, c2); tv = su; end
			2'd2: begin tu = neg(su, c2); tv = neg(sv, c3); end
			2'd3: begin tu = sv; tv = neg(su, c3); end
			default: begin tu = su; tv = sv; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			out_valid <= valid_s1;
		end
	end

	logic signed [31:0] au, av;
	logic c4, c5;
	always_comb begin
		au = tpg_pkg::sat32(66'(u_s1) + 66'({off_s1[15:0], 3'b0}), c4);
		av = tpg_pkg::sat32(66'(v_s1) + 66'({off_s1[31:16], 3'b0}), c5);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1 <= tu; v_s1 <= tv;
			clip_s1 <= in_clip | c0 | c1 | c2 | c3;
			off_s1 <= in_offset;
			out_u <= au; out_v <= av;
			out_clip <= clip_s1 | c4 | c5;
		end
	end
endmodule
`default_nettype wire

/* tb/triplanar_texcoord_generator_tb.sv */
// Testbench for the triplanar texture coordinate generator.
// Drives vertices and quaternion writes, predicts tex coords in a scoreboard class.
// Depends on tpg_pkg, the tpg interfaces and the top level RTL.
module triplanar_texcoord_generator_tb;

	typedef struct {
		logic [31:0] px, py, pz;
		logic [15:0] nx, ny, nz;
		logic [31:0] vu, vv;
		logic [3:0]  mode;
		logic [1:0]  turns;
		logic [15:0] scale;
		logic [31:0] offset;
	} vertex_t;

	typedef struct {
		logic [31:0] u, v;
		logic        sat;
	} texcoord_t;

	class texcoord_scoreboard;
		texcoord_t pending[$];
		longint qw, qx, qy, qz;
		int mismatches;

		function new();
			qw = 64'sd16384;
			qx = 0;
			qy = 0;
			qz = 0;
			mismatches = 0;
		endfunction

		function void set_quat(tpg_pkg::cfg_reg_t idx, logic [15:0] d);
			longint s;
			s = longint'($signed(d));
			case (idx)
				tpg_pkg::REG_QW: qw = s;
				tpg_pkg::REG_QX: qx = s;
				tpg_pkg::REG_QY: qy = s;
				default: qz = s;
			endcase
		endfunction

		static function longint fshr(longint v, int s);
			if (s > 63) s = 63;
			return v >>> s;
		endfunction

		static function longint rshr(longint v, int s);
			if (s == 0) return v;
			return fshr(v + (64'sd1 <<< (s - 1)), s);
		endfunction

		static function longint clamp32(longint v, ref bit clip);
			if (v > 64'sd2147483647) begin
				clip = 1;
				return 64'sd2147483647;
			end
			if (v < -64'sd2147483648) begin
				clip = 1;
				return -64'sd2147483648;
			end
			return v;
		endfunction

		static function longint absv(longint v);
			return v < 0 ? -v : v;
		endfunction

		static function void pick_auto(longint p[3], longint n[3], ref longint u,
			ref longint v);
			if (absv(n[0]) < absv(n[1]) && absv(n[2]) < absv(n[1])) begin
				u = p[0];
				v = p[2];
			end else if (absv(n[0]) < absv(n[2])) begin
				u = p[0];
				v = p[1];
			end else begin
				u = p[2];
				v = p[1];
			end
		endfunction

		static function void pick_plane(int sel, longint p[3], ref longint u,
			ref longint v);
			if (sel == 1) begin
				u = p[2];
				v = p[1];
			end else if (sel == 2) begin
				u = p[0];
				v = p[2];
			end else begin
				u = p[0];
				v = p[1];
			end
		endfunction

		static function longint scale_by(longint v, longint e, ref bit clip);
			if (e < 0) return fshr(v, int'(-e));
			if (v == 0) return 0;
			if (e >= 32) return clamp32(v < 0 ? -64'sd4000000000 : 64'sd4000000000, clip);
			return clamp32(v * (64'sd1 <<< e), clip);
		endfunction

		function texcoord_t project(vertex_t it);
			longint p[3], n[3], lp[3], ln[3], m[3][3];
			longint u, v, t, w, x, y, z;
			bit clip;
			texcoord_t r;
			clip = 0;
			u = 0;
			v = 0;
			p[0] = longint'($signed(it.px));
			p[1] = longint'($signed(it.py));
			p[2] = longint'($signed(it.pz));
			n[0] = longint'($signed(it.nx));
			n[1] = longint'($signed(it.ny));
			n[2] = longint'($signed(it.nz));
			if (it.mode >= tpg_pkg::MODE_LAUTO && it.mode <= tpg_pkg::MODE_LXY) begin
				w = qw; x = qx; y = qy; z = qz;
				m[0][0] = w*w + x*x - y*y - z*z;
				m[0][1] = 2*(x*y - w*z);
				m[0][2] = 2*(x*z + w*y);
				m[1][0] = 2*(x*y + w*z);
				m[1][1] = w*w - x*x + y*y - z*z;
				m[1][2] = 2*(y*z - w*x);
				m[2][0] = 2*(x*z - w*y);
				m[2][1] = 2*(y*z + w*x);
				m[2][2] = w*w - x*x - y*y + z*z;
				for (int r_ = 0; r_ < 3; r_++)
					for (int c = 0; c < 3; c++)
						m[r_][c] = rshr(m[r_][c], tpg_pkg::UNIT_FRAC);
				for (int i = 0; i < 3; i++) begin
					lp[i] = clamp32(rshr(m[i][0]*p[0] + m[i][1]*p[1] + m[i][2]*p[2],
						tpg_pkg::UNIT_FRAC), clip);
					ln[i] = rshr(m[i][0]*n[0] + m[i][1]*n[1] + m[i][2]*n[2],
						tpg_pkg::UNIT_FRAC);
				end
				if (it.mode == tpg_pkg::MODE_LAUTO) pick_auto(lp, ln, u, v);
				else pick_plane(int'(it.mode) - 4, lp, u, v);
			end else if (it.mode == tpg_pkg::MODE_WAUTO) begin
				pick_auto(p, n, u, v);
			end else if (it.mode <= tpg_pkg::MODE_WXY) begin
				pick_plane(int'(it.mode), p, u, v);
			end else begin
				u = longint'($signed(it.vu));
				v = longint'($signed(it.vv));
			end
			u = scale_by(u, longint'($signed(it.scale[7:0])), clip);
			v = scale_by(v, longint'($signed(it.scale[15:8])), clip);
			case (it.turns)
				2'd1: begin
					t = clamp32(-v, clip);
					v = u;
					u = t;
				end
				2'd2: begin
					u = clamp32(-u, clip);
					v = clamp32(-v, clip);
				end
				2'd3: begin
					t = clamp32(-u, clip);
					u = v;
					v = t;
				end
				default: ;
			endcase
			u = clamp32(u + (longint'(it.offset[15:0])
				<<< (tpg_pkg::COORD_FRAC - tpg_pkg::OFFSET_FRAC)), clip);
			v = clamp32(v + (longint'(it.offset[31:16])
				<<< (tpg_pkg::COORD_FRAC - tpg_pkg::OFFSET_FRAC)), clip);
			r.u = u[31:0];
			r.v = v[31:0];
			r.sat = clip;
			return r;
		endfunction

		function void note_vertex(vertex_t it);
			pending.insert(pending.size(), project(it));
		endfunction

		function void check_result(logic [31:0] u, logic [31:0] v, logic sat);
			texcoord_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result u=%h v=%h sat=%b", u, v, sat);
				return;
			end
			e = pending.pop_front();
			if (e.u !== u || e.v !== v || e.sat !== sat) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp u=%h v=%h sat=%b, got u=%h v=%h sat=%b",
						e.u, e.v, e.sat, u, v, sat);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	always #5 clk = ~clk;

	tpg_cfg_if cfg();
	tpg_vert_if vert();
	tpg_tex_if tex();

	triplanar_texcoord_generator dut (
		.clk(clk), .arst_n(arst_n), .cfg(cfg.sink), .vert(vert.sink), .tex(tex.source)
	);

	texcoord_scoreboard sb = new();
	int send_idle_pct = 22;
	int recv_idle_pct = 71;
	bit recv_hold = 0;
	longint cycles = 0;

	initial begin
		cfg.valid = 0;
		cfg.index = tpg_pkg::REG_QW;
		cfg.wdata = 0;
		vert.valid = 0;
		vert.pos_x = 0; vert.pos_y = 0; vert.pos_z = 0;
		vert.norm_x = 0; vert.norm_y = 0; vert.norm_z = 0;
		vert.vert_u = 0; vert.vert_v = 0;
		vert.proj_mode = tpg_pkg::MODE_WAUTO;
		vert.quarter_turns = 0;
		vert.scale_pair = 0;
		vert.offset_pair = 0;
		tex.ready = 0;
	end

	// input transfers feed the predictor; results are checked at the same edge
	always @(posedge clk) begin
		vertex_t it;
		cycles <= cycles + 1;
		if (vert.valid && vert.ready) begin
			it.px = vert.pos_x; it.py = vert.pos_y; it.pz = vert.pos_z;
			it.nx = vert.norm_x; it.ny = vert.norm_y; it.nz = vert.norm_z;
			it.vu = vert.vert_u; it.vv = vert.vert_v;
			it.mode = vert.proj_mode; it.turns = vert.quarter_turns;
			it.scale = vert.scale_pair; it.offset = vert.offset_pair;
			sb.note_vertex(it);
		end
		if (tex.valid && tex.ready)
			sb.check_result(tex.tex_u, tex.tex_v, tex.saturated);
		if (cycles == 2000000) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (recv_hold) tex.ready <= 1'b0;
		else tex.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic write_quat(tpg_pkg::cfg_reg_t idx, logic [15:0] d);
		cfg.index <= idx;
		cfg.wdata <= d;
		cfg.valid <= 1'b1;
		do @(posedge clk); while (!cfg.ready);
		sb.set_quat(idx, d);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic send_vertex(vertex_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			vert.valid <= 1'b0;
			@(posedge clk);
		end
		vert.pos_x <= it.px; vert.pos_y <= it.py; vert.pos_z <= it.pz;
		vert.norm_x <= it.nx; vert.norm_y <= it.ny; vert.norm_z <= it.nz;
		vert.vert_u <= it.vu; vert.vert_v <= it.vv;
		vert.proj_mode <= it.mode; vert.quarter_turns <= it.turns;
		vert.scale_pair <= it.scale; vert.offset_pair <= it.offset;
		vert.valid <= 1'b1;
		do @(posedge clk); while (!vert.ready);
	endtask

	task automatic idle_input();
		vert.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom;
			default: return $signed($urandom_range(65535 * 64)) - 32'sd2097120;
		endcase
	endfunction

	function automatic logic [15:0] rand_unit();
		case ($urandom_range(4))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'($urandom);
			default: return 16'($signed($urandom_range(32768)) - 16384);
		endcase
	endfunction

	function automatic logic [7:0] rand_exp();
		case ($urandom_range(3))
			0: return 8'($urandom);
			default: return 8'($signed($urandom_range(8)) - 4);
		endcase
	endfunction

	function automatic vertex_t rand_vertex();
		vertex_t it;
		it.px = rand_coord(); it.py = rand_coord(); it.pz = rand_coord();
		it.nx = rand_unit(); it.ny = rand_unit(); it.nz = rand_unit();
		if ($urandom_range(5) == 0) it.ny = it.nx;
		it.vu = rand_coord(); it.vv = rand_coord();
		it.mode = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9))
			: 4'($urandom_range(8));
		it.turns = 2'($urandom);
		it.scale = {rand_exp(), rand_exp()};
		it.offset = $urandom;
		return it;
	endfunction

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++) send_vertex(rand_vertex());
		idle_input();
	endtask

	task automatic set_quaternion(logic [15:0] w, logic [15:0] x, logic [15:0] y,
		logic [15:0] z);
		drain();
		write_quat(tpg_pkg::REG_QW, w);
		write_quat(tpg_pkg::REG_QX, x);
		write_quat(tpg_pkg::REG_QY, y);
		write_quat(tpg_pkg::REG_QZ, z);
		cfg.valid <= 1'b0;
		repeat (3) @(posedge clk);
	endtask

	initial begin
		vertex_t it;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every mode, extreme fields, saturating scale and negation
		for (int m = 0; m < 16; m++) begin
			it = rand_vertex();
			it.mode = 4'(m);
			it.turns = m[1:0];
			if (m == 2) begin
				it.nx = 16'd100; it.ny = 16'd100; it.nz = 16'd100;
			end
			if (m == 3) begin
				it.px = 32'h80000000; it.py = 32'h80000000; it.pz = 32'h80000000;
				it.vu = 32'h80000000; it.vv = 32'h80000000; it.turns = 2'd2;
				it.scale = 16'h0000; it.offset = 32'h0;
			end
			if (m == 8) begin
				it.vu = 32'h7fffffff; it.vv = 32'h80000000;
				it.scale = 16'h7f80; it.offset = 32'hffffffff;
			end
			if (m == 9) it.scale = 16'h8020;
			send_vertex(it);
		end
		idle_input();

		set_quaternion(16'h2d41, 16'h2d41, 16'h0000, 16'h0000);
		random_phase(200);
		// long receiver stall while inputs keep coming
		recv_hold = 1;
		fork
			random_phase(40);
			begin
				repeat (300) @(posedge clk);
				recv_hold = 0;
			end
		join
		set_quaternion(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
		random_phase(150);
		send_idle_pct = 71;
		recv_idle_pct = 22;
		set_quaternion(16'h2000, 16'h2000, 16'h2000, 16'h2000);
		random_phase(200);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_quaternion(16'h8000, 16'h0000, 16'h0000, 16'h0000);
		random_phase(200);
		set_quaternion(16'h0000, 16'h4000, 16'h0000, 16'h0000);
		random_phase(50);

		drain();
		if (sb.mismatches == 0 && sb.pending.size() == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end
endmodule
